// ===== hw/rtl/sccp_pkg.sv =====
// ----------------------------------------------------------------------------
// sccp_pkg
// Shared types, codes and helpers of the serial calendar clock port.
// ----------------------------------------------------------------------------
package sccp_pkg;

	localparam int INPUT_SHIFT_BITS_DEF = 64;
	localparam int OUT_W = 52;
	localparam int WORD_W = 48;
	localparam int SET_MIN_BITS = 48;
	localparam int YEAR_PIVOT = 80;
	localparam int YEAR_CENTURY = 100;

	localparam int LINE_STROBE = 3;
	localparam int LINE_CLOCK = 4;
	localparam int LINE_DATA = 5;

	localparam logic [3:0] OPC_CLEAR = 4'd1;
	localparam logic [3:0] OPC_SET = 4'd2;
	localparam logic [3:0] OPC_LATCH = 4'd3;
	localparam logic [3:0] OPC_EXT = 4'd7;

	localparam int CFG_ADDR_W = 3;
	localparam logic REG_EXT_MODE = 1'b0;
	localparam logic EXT_MODE_RESET = 1'b1;

	typedef struct packed {
		logic [7:0] port_value;
		logic [5:0] now_second;
		logic [5:0] now_minute;
		logic [4:0] now_hour;
		logic [4:0] now_day;
		logic [2:0] now_weekday;
		logic [3:0] now_month;
		logic [6:0] now_year;
	} item_t;

	typedef struct packed {
		logic       serial_out_bit;
		logic       set_valid;
		logic [7:0] set_second;
		logic [7:0] set_minute;
		logic [7:0] set_hour;
		logic [7:0] set_day;
		logic [3:0] set_month;
		logic [8:0] set_year;
	} result_t;

	// tens = v * 205 >> 11, exact for every 7-bit v
	function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  rem;
		prod = 15'(v) * 15'd205;
		tens = prod[14:11];
		rem = v - (7'(tens) << 3) - (7'(tens) << 1);
		return {tens, rem[3:0]};
	endfunction

	function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'b0, b[7:4]};
		return (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
	endfunction

endpackage

// ===== hw/rtl/sccp_in_if.sv =====
// ----------------------------------------------------------------------------
// sccp_in_if
// Item channel into the port: one control port write plus the current time.
// ----------------------------------------------------------------------------
interface sccp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] port_value;
	logic [5:0] now_second;
	logic [5:0] now_minute;
	logic [4:0] now_hour;
	logic [4:0] now_day;
	logic [2:0] now_weekday;
	logic [3:0] now_month;
	logic [6:0] now_year;

	modport source (
		output valid, port_value, now_second, now_minute, now_hour, now_day,
			now_weekday, now_month, now_year,
		input ready
	);
	modport sink (
		input valid, port_value, now_second, now_minute, now_hour, now_day,
			now_weekday, now_month, now_year,
		output ready
	);
endinterface

// ===== hw/rtl/sccp_out_if.sv =====
// ----------------------------------------------------------------------------
// sccp_out_if
// Result channel of the port: output bit and decoded set-time request.
// ----------------------------------------------------------------------------
interface sccp_out_if;
	logic       valid;
	logic       ready;
	logic       serial_out_bit;
	logic       set_valid;
	logic [7:0] set_second;
	logic [7:0] set_minute;
	logic [7:0] set_hour;
	logic [7:0] set_day;
	logic [3:0] set_month;
	logic [8:0] set_year;

	modport source (
		output valid, serial_out_bit, set_valid, set_second, set_minute, set_hour,
			set_day, set_month, set_year,
		input ready
	);
	modport sink (
		input valid, serial_out_bit, set_valid, set_second, set_minute, set_hour,
			set_day, set_month, set_year,
		output ready
	);
endinterface

// ===== hw/rtl/serial_calendar_clock_port.sv =====
// ----------------------------------------------------------------------------
// serial_calendar_clock_port
// Bit-serial calendar clock command port with APB mode register.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while results are taken, and each gives
// one result item: an input register feeds the single-pass command and shift
// update, whose result lands in an output register that also decouples the
// result channel. The mode register (extended output, address 0) is written
// over APB; the user must do so only while idle, the block does not enforce it.
module serial_calendar_clock_port #(
	parameter int INPUT_SHIFT_BITS = sccp_pkg::INPUT_SHIFT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sccp_in_if.sink                       sample,
	sccp_out_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sccp_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic               valid_s1;
	sccp_pkg::item_t    item_s1;
	sccp_pkg::item_t    item_in;
	logic               out_valid_q;
	sccp_pkg::result_t  res_q;
	sccp_pkg::result_t  res_next;
	logic               ext_mode_q;
	logic               advance;
	logic               take;
	logic               in_ready;
	logic               reg_hit;

	assign advance = !out_valid_q || result.ready;
	assign take = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign sample.ready = in_ready;

	assign item_in = '{
		port_value: sample.port_value,
		now_second: sample.now_second,
		now_minute: sample.now_minute,
		now_hour: sample.now_hour,
		now_day: sample.now_day,
		now_weekday: sample.now_weekday,
		now_month: sample.now_month,
		now_year: sample.now_year
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= sample.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && in_ready) begin
			item_s1 <= item_in;
		end
		if (take) begin
			res_q <= res_next;
		end
	end

	sccp_engine #(
		.INPUT_SHIFT_BITS(INPUT_SHIFT_BITS)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.en(take),
		.item(item_s1),
		.ext_mode(ext_mode_q),
		.res(res_next)
	);

	assign result.valid = out_valid_q;
	assign result.serial_out_bit = res_q.serial_out_bit;
	assign result.set_valid = res_q.set_valid;
	assign result.set_second = res_q.set_second;
	assign result.set_minute = res_q.set_minute;
	assign result.set_hour = res_q.set_hour;
	assign result.set_day = res_q.set_day;
	assign result.set_month = res_q.set_month;
	assign result.set_year = res_q.set_year;

	// APB
	assign pready = 1'b1;
	assign reg_hit = paddr[2] == sccp_pkg::REG_EXT_MODE;
	assign prdata = reg_hit ? {31'b0, ext_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_mode_q <= sccp_pkg::EXT_MODE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			ext_mode_q <= pwdata[0];
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost item under stall");

	a_take_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q)
		else $error("processed item produced no result");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q && $stable(res_q))
		else $error("result item changed while waiting");

endmodule

// ===== hw/rtl/sccp_engine.sv =====
// ----------------------------------------------------------------------------
// sccp_engine
// Line edge detection, command decode, shifters and set-time decode.
// ----------------------------------------------------------------------------
module sccp_engine #(
	parameter int INPUT_SHIFT_BITS = sccp_pkg::INPUT_SHIFT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  sccp_pkg::item_t   item,
	input  logic              ext_mode,
	output sccp_pkg::result_t res
);

	localparam int CNT_W = $clog2(INPUT_SHIFT_BITS + 1);
	localparam int IDX_W = $clog2(INPUT_SHIFT_BITS);

	logic [7:0]                    prev_q;
	logic [3:0]                    cmd_q;
	logic [sccp_pkg::OUT_W-1:0]    osh_q;
	logic [INPUT_SHIFT_BITS-1:0]   ish_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [3:0]                    op_q;

	logic [3:0]                    cmd_n;
	logic [sccp_pkg::OUT_W-1:0]    osh_n;
	logic [INPUT_SHIFT_BITS-1:0]   ish_n;
	logic [CNT_W-1:0]              cnt_n;
	logic [3:0]                    op_n;

	logic                          strobe_fall;
	logic                          clock_fall;
	logic                          din;
	logic [sccp_pkg::WORD_W-1:0]   word;
	logic [sccp_pkg::OUT_W-1:0]    latch_word;
	logic [7:0]                    year_bin;

	assign strobe_fall = prev_q[sccp_pkg::LINE_STROBE] & ~item.port_value[sccp_pkg::LINE_STROBE];
	assign clock_fall = prev_q[sccp_pkg::LINE_CLOCK] & ~item.port_value[sccp_pkg::LINE_CLOCK];
	assign din = prev_q[sccp_pkg::LINE_DATA];

	assign word = {
		sccp_pkg::bin_to_bcd(item.now_year),
		item.now_month,
		1'b0, item.now_weekday,
		sccp_pkg::bin_to_bcd({2'b0, item.now_day}),
		sccp_pkg::bin_to_bcd({2'b0, item.now_hour}),
		sccp_pkg::bin_to_bcd({1'b0, item.now_minute}),
		sccp_pkg::bin_to_bcd({1'b0, item.now_second})
	};
	assign latch_word = ext_mode ? {word, 4'b0} : {4'b0, word};
	assign year_bin = sccp_pkg::bcd_to_bin(ish_q[47:40]);

	always_comb begin
		cmd_n = cmd_q;
		osh_n = osh_q;
		ish_n = ish_q;
		cnt_n = cnt_q;
		op_n = op_q;
		res = '0;
		if (strobe_fall) begin
			cmd_n = {1'b0, prev_q[2:0]};
			case (cmd_n)
				sccp_pkg::OPC_LATCH: begin
					osh_n = latch_word;
				end
				sccp_pkg::OPC_CLEAR: begin
					ish_n = '0;
					cnt_n = '0;
				end
				sccp_pkg::OPC_SET: begin
					if (cnt_q >= CNT_W'(sccp_pkg::SET_MIN_BITS)) begin
						res.set_valid = 1'b1;
						res.set_second = sccp_pkg::bcd_to_bin(ish_q[7:0]);
						res.set_minute = sccp_pkg::bcd_to_bin(ish_q[15:8]);
						res.set_hour = sccp_pkg::bcd_to_bin(ish_q[23:16]);
						res.set_day = sccp_pkg::bcd_to_bin(ish_q[31:24]);
						res.set_month = ish_q[39:36];
						res.set_year = (year_bin < 8'(sccp_pkg::YEAR_PIVOT)) ?
							{1'b0, year_bin} + 9'(sccp_pkg::YEAR_CENTURY) : {1'b0, year_bin};
					end
				end
				sccp_pkg::OPC_EXT: begin
					cmd_n = op_q;
					if (op_q == sccp_pkg::OPC_LATCH) begin
						osh_n = latch_word;
					end
				end
				default: begin
				end
			endcase
		end
		if (clock_fall) begin
			if (cmd_n == sccp_pkg::OPC_CLEAR && cnt_n < CNT_W'(INPUT_SHIFT_BITS)) begin
				ish_n[cnt_n[IDX_W-1:0]] = ish_n[cnt_n[IDX_W-1:0]] | din;
				cnt_n = cnt_n + CNT_W'(1);
			end else begin
				op_n = {din, op_q[3:1]};
			end
			osh_n = osh_n >> 1;
		end
		res.serial_out_bit = osh_n[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			cmd_q <= '0;
			osh_q <= '0;
			ish_q <= '0;
			cnt_q <= '0;
			op_q <= '0;
		end else if (en) begin
			prev_q <= item.port_value;
			cmd_q <= cmd_n;
			osh_q <= osh_n;
			ish_q <= ish_n;
			cnt_q <= cnt_n;
			op_q <= op_n;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(INPUT_SHIFT_BITS))
		else $error("input bit count beyond shifter size");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(cnt_q) && $stable(cmd_q) && $stable(osh_q))
		else $error("state moved without an item");

	a_cmd_needs_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		en && !strobe_fall |=> cmd_q == $past(cmd_q))
		else $error("command changed without strobe edge");

	a_set_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!res.set_valid |-> res.set_second == '0 && res.set_year == '0 && res.set_month == '0)
		else $error("set fields nonzero without set request");

endmodule

// ===== tb/serial_calendar_clock_port_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_calendar_clock_port_tb
// Drives strobe, clock and data writes with time samples into the port and
// checks every result item against an in-bench model of the command decode,
// input and opcode shifters and the output time latch. Runs in both output
// modes with mixed idling on both channels and one long result hold.
// ----------------------------------------------------------------------------
module serial_calendar_clock_port_tb;

	localparam logic [2:0] CMD_NONE = 3'd0;
	localparam logic [2:0] CMD_SPARE_A = 3'd4;
	localparam logic [2:0] CMD_SPARE_B = 3'd5;
	localparam logic [2:0] CMD_SPARE_C = 3'd6;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 425;

	class clock_port_tracker;
		logic                ext_mode;
		logic [7:0]          last_lines;
		logic [3:0]          command;
		logic [51:0]         out_word;
		logic [63:0]         in_word;
		logic [6:0]          in_count;
		logic [3:0]          opcode;
		sccp_pkg::result_t   due_results[$];
		int                  errors;
		int                  checked;
		int                  set_requests;

		function new();
			ext_mode = sccp_pkg::EXT_MODE_RESET;
			last_lines = '0;
			command = '0;
			out_word = '0;
			in_word = '0;
			in_count = '0;
			opcode = '0;
			errors = 0;
			checked = 0;
			set_requests = 0;
		endfunction

		static function logic [7:0] to_bcd(int v);
			return 8'(((v / 10) << 4) | (v % 10));
		endfunction

		static function int bcd_value(logic [7:0] b);
			return int'(b[7:4]) * 10 + int'(b[3:0]);
		endfunction

		function void latch_time(sccp_pkg::item_t it);
			logic [47:0] w;
			w = {to_bcd(it.now_year), it.now_month, 1'b0, it.now_weekday,
				to_bcd(it.now_day), to_bcd(it.now_hour), to_bcd(it.now_minute),
				to_bcd(it.now_second)};
			out_word = ext_mode ? {w, 4'b0} : {4'b0, w};
		endfunction

		function void note_write(sccp_pkg::item_t it);
			sccp_pkg::result_t want;
			logic              d;
			int                yr;
			want = '0;
			if (last_lines[sccp_pkg::LINE_STROBE] && !it.port_value[sccp_pkg::LINE_STROBE]) begin
				command = {1'b0, last_lines[2:0]};
				case (command)
					sccp_pkg::OPC_LATCH: latch_time(it);
					sccp_pkg::OPC_CLEAR: begin
						in_word = '0;
						in_count = '0;
					end
					sccp_pkg::OPC_SET: begin
						if (in_count >= sccp_pkg::SET_MIN_BITS) begin
							want.set_valid = 1'b1;
							want.set_second = 8'(bcd_value(in_word[7:0]));
							want.set_minute = 8'(bcd_value(in_word[15:8]));
							want.set_hour = 8'(bcd_value(in_word[23:16]));
							want.set_day = 8'(bcd_value(in_word[31:24]));
							want.set_month = in_word[39:36];
							yr = bcd_value(in_word[47:40]);
							if (yr < sccp_pkg::YEAR_PIVOT)
								yr += sccp_pkg::YEAR_CENTURY;
							want.set_year = 9'(yr);
							set_requests++;
						end
					end
					sccp_pkg::OPC_EXT: begin
						command = opcode;
						if (command == sccp_pkg::OPC_LATCH)
							latch_time(it);
					end
					default: ;
				endcase
			end
			if (last_lines[sccp_pkg::LINE_CLOCK] && !it.port_value[sccp_pkg::LINE_CLOCK]) begin
				d = last_lines[sccp_pkg::LINE_DATA];
				if (command == sccp_pkg::OPC_CLEAR &&
					in_count < sccp_pkg::INPUT_SHIFT_BITS_DEF) begin
					in_word[in_count[5:0]] = in_word[in_count[5:0]] | d;
					in_count++;
				end else begin
					opcode = {d, opcode[3:1]};
				end
				out_word = out_word >> 1;
			end
			last_lines = it.port_value;
			want.serial_out_bit = out_word[0];
			due_results.push_back(want);
		endfunction

		function void compare(string field, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
					$time, field, want, got);
			end
		endfunction

		function void check_reply(sccp_pkg::result_t got);
			sccp_pkg::result_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t ns: result item with nothing expected", $time);
				return;
			end
			want = due_results.pop_front();
			checked++;
			compare("serial_out_bit", want.serial_out_bit, got.serial_out_bit);
			compare("set_valid", want.set_valid, got.set_valid);
			compare("set_second", want.set_second, got.set_second);
			compare("set_minute", want.set_minute, got.set_minute);
			compare("set_hour", want.set_hour, got.set_hour);
			compare("set_day", want.set_day, got.set_day);
			compare("set_month", want.set_month, got.set_month);
			compare("set_year", want.set_year, got.set_year);
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [sccp_pkg::CFG_ADDR_W-1:0] paddr;
	logic [31:0]                     pwdata;
	logic [31:0]                     prdata;
	logic                            pready;

	sccp_in_if  port_ch ();
	sccp_out_if reply_ch ();

	clock_port_tracker tracker;
	sccp_pkg::item_t   now_tmpl;
	int                send_idle_pct;
	int                recv_stall_pct;
	int                hold_left;
	int                items_sent;

	serial_calendar_clock_port dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (port_ch),
		.result  (reply_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

	// result side: check on handshake, then pick ready for the next edge
	initial begin
		sccp_pkg::result_t got;
		reply_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && reply_ch.valid === 1'b1 && reply_ch.ready === 1'b1) begin
				got.serial_out_bit = reply_ch.serial_out_bit;
				got.set_valid = reply_ch.set_valid;
				got.set_second = reply_ch.set_second;
				got.set_minute = reply_ch.set_minute;
				got.set_hour = reply_ch.set_hour;
				got.set_day = reply_ch.set_day;
				got.set_month = reply_ch.set_month;
				got.set_year = reply_ch.set_year;
				tracker.check_reply(got);
			end
			if (hold_left > 0) begin
				reply_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				reply_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [7:0] port_byte(logic strobe, logic clock, logic data,
		logic [2:0] cmd);
		return {2'($urandom), data, clock, strobe, cmd};
	endfunction

	task automatic send_item(input sccp_pkg::item_t it);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			port_ch.valid <= 1'b0;
			@(posedge clk);
		end
		port_ch.valid <= 1'b1;
		port_ch.port_value <= it.port_value;
		port_ch.now_second <= it.now_second;
		port_ch.now_minute <= it.now_minute;
		port_ch.now_hour <= it.now_hour;
		port_ch.now_day <= it.now_day;
		port_ch.now_weekday <= it.now_weekday;
		port_ch.now_month <= it.now_month;
		port_ch.now_year <= it.now_year;
		do @(posedge clk); while (port_ch.ready !== 1'b1);
		tracker.note_write(it);
		items_sent++;
	endtask

	task automatic send_pv(input logic [7:0] pv);
		sccp_pkg::item_t it;
		it = now_tmpl;
		it.port_value = pv;
		send_item(it);
	endtask

	task automatic issue_command(input logic [2:0] cmd);
		send_pv(port_byte(1'b1, 1'b0, 1'($urandom), cmd));
		send_pv(port_byte(1'b0, 1'b0, 1'($urandom), 3'($urandom)));
	endtask

	task automatic clock_bit(input logic d);
		send_pv(port_byte(1'b0, 1'b1, d, 3'($urandom)));
		send_pv(port_byte(1'b0, 1'b0, 1'($urandom), 3'($urandom)));
	endtask

	task automatic pick_time(input bit wild);
		if (wild) begin
			now_tmpl.now_second = 6'($urandom);
			now_tmpl.now_minute = 6'($urandom);
			now_tmpl.now_hour = 5'($urandom);
			now_tmpl.now_day = 5'($urandom);
			now_tmpl.now_weekday = 3'($urandom);
			now_tmpl.now_month = 4'($urandom);
			now_tmpl.now_year = 7'($urandom);
		end else begin
			now_tmpl.now_second = 6'($urandom_range(59));
			now_tmpl.now_minute = 6'($urandom_range(59));
			now_tmpl.now_hour = 5'($urandom_range(23));
			now_tmpl.now_day = 5'($urandom_range(31, 1));
			now_tmpl.now_weekday = 3'($urandom_range(6));
			now_tmpl.now_month = 4'($urandom_range(12, 1));
			now_tmpl.now_year = 7'($urandom_range(99));
		end
	endtask

	task automatic write_mode(input logic m);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sccp_pkg::REG_EXT_MODE, 2'b00};
		pwdata <= {31'b0, m};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.ext_mode = m;
	endtask

	task automatic drain();
		port_ch.valid <= 1'b0;
		while (tracker.due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_sequence();
		int          pick;
		int          n;
		logic [63:0] word;
		logic [3:0]  opc;
		pick = $urandom_range(99);
		pick_time($urandom_range(7) == 0);
		if (pick < 40) begin
			// load a time word, then ask for a set
			issue_command(sccp_pkg::OPC_CLEAR[2:0]);
			case ($urandom_range(6))
				0: n = 47;
				1: n = 48;
				2: n = 64;
				3: n = 70;
				default: n = $urandom_range(60, 44);
			endcase
			if ($urandom_range(1))
				word = {$urandom, $urandom};
			else
				word = {16'($urandom), clock_port_tracker::to_bcd($urandom_range(99)),
					4'($urandom_range(12, 1)), 1'($urandom), 3'($urandom_range(6)),
					clock_port_tracker::to_bcd($urandom_range(31, 1)),
					clock_port_tracker::to_bcd($urandom_range(23)),
					clock_port_tracker::to_bcd($urandom_range(59)),
					clock_port_tracker::to_bcd($urandom_range(59))};
			for (int i = 0; i < n; i++)
				clock_bit(word[i % 64]);
			issue_command(sccp_pkg::OPC_SET[2:0]);
		end else if (pick < 58) begin
			issue_command(sccp_pkg::OPC_LATCH[2:0]);
			repeat ($urandom_range(56, 1)) clock_bit(1'($urandom));
		end else if (pick < 72) begin
			// opcode shifted in serially, then the extended command
			opc = $urandom_range(1) ? sccp_pkg::OPC_LATCH : 4'($urandom);
			issue_command(CMD_NONE);
			for (int i = 0; i < 4; i++)
				clock_bit(opc[i]);
			issue_command(sccp_pkg::OPC_EXT[2:0]);
			repeat ($urandom_range(6)) clock_bit(1'($urandom));
		end else if (pick < 80) begin
			repeat ($urandom_range(6, 1)) send_pv(8'($urandom));
		end else if (pick < 88) begin
			issue_command(3'($urandom));
		end else if (pick < 93) begin
			// strobe and clock drop in the same write
			send_pv(port_byte(1'b1, 1'b1, 1'($urandom), 3'($urandom)));
			send_pv(port_byte(1'b0, 1'b0, 1'($urandom), 3'($urandom)));
		end else begin
			repeat ($urandom_range(8, 1)) clock_bit(1'($urandom));
		end
	endtask

	initial begin
		int idle_tab[4];
		int stall_tab[4];
		int target;
		idle_tab = '{0, 51, 0, 13};
		stall_tab = '{0, 0, 51, 13};
		tracker = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		port_ch.valid = 1'b0;
		port_ch.port_value = '0;
		port_ch.now_second = '0;
		port_ch.now_minute = '0;
		port_ch.now_hour = '0;
		port_ch.now_day = '0;
		port_ch.now_weekday = '0;
		port_ch.now_month = '0;
		port_ch.now_year = '0;
		now_tmpl = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		items_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, both lines falling together, every command
		send_pv(8'h00);
		now_tmpl.now_second = '1;
		now_tmpl.now_minute = '1;
		now_tmpl.now_hour = '1;
		now_tmpl.now_day = '1;
		now_tmpl.now_weekday = '1;
		now_tmpl.now_month = '1;
		now_tmpl.now_year = '1;
		send_pv(8'hff);
		send_pv(8'h00);
		now_tmpl.now_second = 6'd59;
		now_tmpl.now_minute = 6'd59;
		now_tmpl.now_hour = 5'd23;
		now_tmpl.now_day = 5'd31;
		now_tmpl.now_weekday = 3'd6;
		now_tmpl.now_month = 4'd12;
		now_tmpl.now_year = 7'd99;
		issue_command(sccp_pkg::OPC_LATCH[2:0]);
		clock_bit(1'b1);
		clock_bit(1'b0);
		issue_command(sccp_pkg::OPC_CLEAR[2:0]);
		clock_bit(1'b1);
		issue_command(sccp_pkg::OPC_SET[2:0]);
		issue_command(CMD_NONE);
		issue_command(CMD_SPARE_A);
		issue_command(CMD_SPARE_B);
		issue_command(CMD_SPARE_C);

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_mode(ph[0]);
			send_idle_pct = idle_tab[ph];
			recv_stall_pct = stall_tab[ph];
			if (ph == 0)
				hold_left = HOLD_CYCLES;
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target)
				run_sequence();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		repeat (8) @(posedge clk);
		$display("tb: %0d port writes, %0d result items checked, %0d set requests decoded",
			items_sent, tracker.checked, tracker.set_requests);
		$display("tb: both output modes, idle and stall mixes and a long result hold run");
		if (tracker.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
